/* design/eidsig_pkg.sv */
// Shared constants, codes and interface types of the entity table engine.
package eidsig_pkg;

    localparam int MAX_ENTITIES        = 64;
    localparam int MAX_COMPONENT_TYPES = 32;

    // Fixed field widths
    localparam int REQ_W  = 3;
    localparam int ID_W   = 6;
    localparam int CID_W  = 6;
    localparam int MASK_W = 32;
    localparam int STAT_W = 2;

    localparam int ENT_IDX_W = (MAX_ENTITIES > 1) ? $clog2(MAX_ENTITIES) : 1;
    localparam int CNT_W     = $clog2(MAX_ENTITIES + 1);
    localparam int SH_W      = $clog2(MASK_W);

    localparam logic [ID_W:0]      EID_LIMIT = (ID_W + 1)'(MAX_ENTITIES);
    localparam logic [CID_W-1:0]   CID_MAX   = CID_W'(MAX_COMPONENT_TYPES);
    localparam logic [CNT_W-1:0]   ENT_COUNT = CNT_W'(MAX_ENTITIES);
    localparam logic [MASK_W-1:0]  LEGAL_MASK =
        (MAX_COMPONENT_TYPES >= MASK_W) ? {MASK_W{1'b1}} :
        MASK_W'((64'd1 << MAX_COMPONENT_TYPES) - 64'd1);

    // Request codes
    localparam logic [REQ_W-1:0] REQ_CREATE   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_IS_ALIVE = 3'd1;
    localparam logic [REQ_W-1:0] REQ_KILL     = 3'd2;
    localparam logic [REQ_W-1:0] REQ_ADD      = 3'd3;
    localparam logic [REQ_W-1:0] REQ_REMOVE   = 3'd4;
    localparam logic [REQ_W-1:0] REQ_QUERY    = 3'd5;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_NO_FREE   = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOT_ALIVE = 2'd2;
    localparam logic [STAT_W-1:0] ST_BAD_COMP  = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic                 pop;
        logic                 push;
        logic [ENT_IDX_W-1:0] push_id;
    } fq_cmd_t;

    typedef struct packed {
        logic [ID_W-1:0] head_id;
        logic            empty;
        logic            full;
    } fq_stat_t;

    typedef struct packed {
        logic                 rd_en;
        logic [ENT_IDX_W-1:0] rd_addr;
    } tab_req_t;

    typedef struct packed {
        logic                 alive_set;
        logic                 alive_clr;
        logic                 sig_wr;
        logic [ENT_IDX_W-1:0] ent;
        logic [MASK_W-1:0]    sig_data;
    } tab_cmd_t;

    typedef struct packed {
        logic              alive;
        logic [MASK_W-1:0] sig;
    } tab_rd_t;

endpackage

/* design/entity_id_allocator_with_signatures.sv */
// Entity table engine top level: allocates entity IDs from a first-in first-out free list,
// tracks alive entities and their component signatures, and answers component queries.
// Requests are handled one at a time. For a create, is-alive, kill, add or remove request,
// the accept cycle issues the reads of the free-list and signature memories, and the exec
// state checks the request, writes the memories back and loads the result register,
// waiting while the output is stalled. A query walks the signature memory through its
// single read port, one entity per cycle unless a stalled output holds the walk, and
// holds each match back one step so that the last match can carry tlast. A query with
// an illegal mask bit answers from the exec state without a scan. The result register
// lets a new item be accepted while the previous result is still waiting; a stalled
// output stops the scan only when a further match needs the register.
// The ID list and signature memories need no clearing pass after reset: per-entry
// flags make never-written entries read as their reset contents.
module entity_id_allocator_with_signatures
    import eidsig_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // Request items
    input  logic        s_tvalid,
    output logic        s_tready,
    // [2:0] req_type, [8:3] entity_id, [14:9] component_id, [46:15] component_mask
    input  logic [47:0] s_tdata,
    // Result items
    output logic        m_tvalid,
    input  logic        m_tready,
    // [5:0] result_id, [6] id_valid, [7] alive_flag, [9:8] status
    output logic [15:0] m_tdata,
    output logic        m_tlast
);

    localparam int EID_LSB  = REQ_W;
    localparam int CID_LSB  = EID_LSB + ID_W;
    localparam int MASK_LSB = CID_LSB + CID_W;
    localparam int RES_BITS = ID_W + 1 + 1 + STAT_W;

    state_t state_reg, state_next;

    // Captured request
    logic [REQ_W-1:0]  req_type_reg;
    logic [ID_W-1:0]   eid_reg;
    logic [CID_W-1:0]  cid_reg;
    logic [MASK_W-1:0] mask_reg;

    // Scan pipeline: read stage, compare stage, held match
    logic [CNT_W-1:0]     scan_idx_reg, scan_idx_next;
    logic                 ev_valid_reg, ev_valid_next;
    logic [ENT_IDX_W-1:0] ev_idx_reg, ev_idx_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic [ENT_IDX_W-1:0] pend_idx_reg, pend_idx_next;

    // Result register
    logic                m_tvalid_reg;
    logic [15:0]         m_tdata_reg;
    logic                m_tlast_reg;
    logic                out_load;
    logic [ID_W-1:0]     o_id;
    logic                o_id_valid;
    logic                o_alive;
    logic [STAT_W-1:0]   o_status;
    logic                o_last;

    fq_cmd_t  fq_cmd;
    fq_stat_t fq_stat;
    tab_req_t tab_req;
    tab_cmd_t tab_cmd;
    tab_rd_t  tab_rd;

    logic                 in_fire;
    logic                 out_free;
    logic [ENT_IDX_W-1:0] eid_idx;
    logic                 eid_in_range;
    logic                 ent_ok;
    logic                 comp_ok;
    logic [CID_W-1:0]     cid_m1;
    logic [MASK_W-1:0]    cbit;
    logic                 mask_bad;
    logic                 query_scan;
    logic                 ev_match;
    logic                 scan_stall;
    logic                 scan_issue;
    logic                 scan_done;

    assign s_tready = (state_reg == S_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // Request checks
    assign eid_idx      = eid_reg[ENT_IDX_W-1:0];
    assign eid_in_range = ((ID_W + 1)'(eid_reg) < EID_LIMIT);
    assign ent_ok       = eid_in_range && tab_rd.alive;
    assign comp_ok      = (cid_reg != '0) && (cid_reg <= CID_MAX);
    assign cid_m1       = cid_reg - CID_W'(1);
    assign cbit         = MASK_W'(1) << cid_m1[SH_W-1:0];
    assign mask_bad     = |(mask_reg & ~LEGAL_MASK);
    assign query_scan   = (req_type_reg == REQ_QUERY) && !mask_bad;

    // Scan control: hold the walk only when a new match finds the held one undeliverable
    assign ev_match   = ev_valid_reg && tab_rd.alive && ((tab_rd.sig & mask_reg) == mask_reg);
    assign scan_stall = ev_match && pend_valid_reg && !out_free;
    assign scan_issue = (state_reg == S_SCAN) && !scan_stall && (scan_idx_reg < ENT_COUNT);
    assign scan_done  = (scan_idx_reg == ENT_COUNT) && !ev_valid_reg;

    // Signature reads: entity of the incoming request, or the scan address
    always_comb begin
        tab_req.rd_en   = in_fire || scan_issue;
        tab_req.rd_addr = in_fire ? s_tdata[EID_LSB +: ENT_IDX_W] :
                                    scan_idx_reg[ENT_IDX_W-1:0];
    end

    eidsig_freeq u_freeq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (in_fire),
        .cmd     (fq_cmd),
        .stat    (fq_stat)
    );

    eidsig_sigtab u_sigtab (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (tab_req),
        .cmd     (tab_cmd),
        .rd      (tab_rd)
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (in_fire) state_next = S_EXEC;
            end
            S_EXEC: begin
                if (query_scan) begin
                    state_next = S_SCAN;
                end else if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            S_SCAN: begin
                if (scan_done) state_next = S_FINISH;
            end
            S_FINISH: begin
                if (out_free) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Outputs and memory write-back
    always_comb begin
        out_load   = 1'b0;
        o_id       = '0;
        o_id_valid = 1'b0;
        o_alive    = 1'b0;
        o_status   = ST_OK;
        o_last     = 1'b1;
        fq_cmd     = '0;
        tab_cmd    = '0;
        unique case (state_reg)
            S_EXEC: begin
                if (!query_scan && out_free) begin
                    out_load = 1'b1;
                    unique case (req_type_reg)
                        REQ_CREATE: begin
                            if (fq_stat.empty) begin
                                o_status = ST_NO_FREE;
                            end else begin
                                o_id              = fq_stat.head_id;
                                o_id_valid        = 1'b1;
                                fq_cmd.pop        = 1'b1;
                                tab_cmd.alive_set = 1'b1;
                                tab_cmd.ent       = fq_stat.head_id[ENT_IDX_W-1:0];
                            end
                        end
                        REQ_IS_ALIVE: begin
                            if (!eid_in_range) begin
                                o_status = ST_NOT_ALIVE;
                            end else begin
                                o_alive = tab_rd.alive;
                            end
                        end
                        REQ_KILL: begin
                            if (!ent_ok) begin
                                o_status = ST_NOT_ALIVE;
                            end else begin
                                tab_cmd.alive_clr = 1'b1;
                                tab_cmd.ent       = eid_idx;
                                fq_cmd.push       = !fq_stat.full;
                                fq_cmd.push_id    = eid_idx;
                            end
                        end
                        REQ_ADD, REQ_REMOVE: begin
                            if (!ent_ok) begin
                                o_status = ST_NOT_ALIVE;
                            end else if (!comp_ok) begin
                                o_status = ST_BAD_COMP;
                            end else begin
                                tab_cmd.sig_wr   = 1'b1;
                                tab_cmd.ent      = eid_idx;
                                tab_cmd.sig_data = (req_type_reg == REQ_ADD) ?
                                                   (tab_rd.sig | cbit) :
                                                   (tab_rd.sig & ~cbit);
                            end
                        end
                        REQ_QUERY: begin
                            // Only an illegal mask reaches this arm
                            o_status = ST_BAD_COMP;
                        end
                        default: begin
                            o_status = ST_OK;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // Release the held match once a later one proves it is not the last
                if (ev_match && pend_valid_reg && out_free) begin
                    out_load   = 1'b1;
                    o_id       = ID_W'(pend_idx_reg);
                    o_id_valid = 1'b1;
                    o_last     = 1'b0;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    out_load = 1'b1;
                    if (pend_valid_reg) begin
                        o_id       = ID_W'(pend_idx_reg);
                        o_id_valid = 1'b1;
                    end
                end
            end
            default: begin
                out_load = 1'b0;
            end
        endcase
    end

    // Scan pipeline next values
    always_comb begin
        scan_idx_next   = scan_idx_reg;
        ev_valid_next   = ev_valid_reg;
        ev_idx_next     = ev_idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        if (state_reg == S_EXEC) begin
            scan_idx_next   = '0;
            ev_valid_next   = 1'b0;
            pend_valid_next = 1'b0;
        end else if (state_reg == S_SCAN && !scan_stall) begin
            ev_valid_next = scan_issue;
            if (scan_issue) begin
                ev_idx_next   = scan_idx_reg[ENT_IDX_W-1:0];
                scan_idx_next = scan_idx_reg + CNT_W'(1);
            end
            if (ev_match) begin
                pend_valid_next = 1'b1;
                pend_idx_next   = ev_idx_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            ev_valid_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
            scan_idx_reg   <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            ev_valid_reg   <= ev_valid_next;
            pend_valid_reg <= pend_valid_next;
            scan_idx_reg   <= scan_idx_next;
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        ev_idx_reg   <= ev_idx_next;
        pend_idx_reg <= pend_idx_next;
        if (in_fire) begin
            req_type_reg <= s_tdata[REQ_W-1:0];
            eid_reg      <= s_tdata[EID_LSB +: ID_W];
            cid_reg      <= s_tdata[CID_LSB +: CID_W];
            mask_reg     <= s_tdata[MASK_LSB +: MASK_W];
        end
        if (out_load) begin
            m_tdata_reg <= {(16 - RES_BITS)'(0), o_status, o_alive, o_id_valid, o_id};
            m_tlast_reg <= o_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

/* design/eidsig_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module eidsig_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                          aclk,
    input  logic                                          wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
    input  logic [WIDTH-1:0]                              wr_data,
    input  logic                                          rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
    output logic [WIDTH-1:0]                              rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* design/eidsig_freeq.sv */
// Free-ID queue: circular buffer in RAM, entries never written read as their own index.
module eidsig_freeq
    import eidsig_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     rd_en,
    input  fq_cmd_t  cmd,
    output fq_stat_t stat
);

    logic [ENT_IDX_W-1:0]    head_reg, head_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [MAX_ENTITIES-1:0] wr_seen_reg, wr_seen_next;
    logic [CNT_W:0]          tail_sum;
    logic [CNT_W:0]          tail_wrap;
    logic [ENT_IDX_W-1:0]    tail_idx;
    logic [ID_W-1:0]         ram_rd;

    // Tail = (head + count) mod depth; the sum stays below twice the depth
    assign tail_sum  = (CNT_W + 1)'(head_reg) + (CNT_W + 1)'(count_reg);
    assign tail_wrap = (tail_sum >= (CNT_W + 1)'(MAX_ENTITIES)) ?
                       tail_sum - (CNT_W + 1)'(MAX_ENTITIES) : tail_sum;
    assign tail_idx  = tail_wrap[ENT_IDX_W-1:0];

    always_comb begin
        head_next    = head_reg;
        count_next   = count_reg;
        wr_seen_next = wr_seen_reg;
        priority if (cmd.pop) begin
            head_next  = (head_reg == ENT_IDX_W'(MAX_ENTITIES - 1)) ?
                         '0 : head_reg + ENT_IDX_W'(1);
            count_next = count_reg - CNT_W'(1);
        end else if (cmd.push) begin
            count_next             = count_reg + CNT_W'(1);
            wr_seen_next[tail_idx] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg    <= '0;
            count_reg   <= ENT_COUNT;
            wr_seen_reg <= '0;
        end else begin
            head_reg    <= head_next;
            count_reg   <= count_next;
            wr_seen_reg <= wr_seen_next;
        end
    end

    eidsig_ram #(
        .WIDTH (ID_W),
        .DEPTH (MAX_ENTITIES)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (cmd.push),
        .wr_addr (tail_idx),
        .wr_data (ID_W'(cmd.push_id)),
        .rd_en   (rd_en),
        .rd_addr (head_reg),
        .rd_data (ram_rd)
    );

    assign stat.head_id = wr_seen_reg[head_reg] ? ram_rd : ID_W'(head_reg);
    assign stat.empty   = (count_reg == '0);
    assign stat.full    = (count_reg == ENT_COUNT);

endmodule

/* design/eidsig_sigtab.sv */
// Entity table: alive flags plus component signatures in RAM with per-entry valid bits.
module eidsig_sigtab
    import eidsig_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  tab_req_t req,
    input  tab_cmd_t cmd,
    output tab_rd_t  rd
);

    logic [MAX_ENTITIES-1:0] ent_vld_reg, ent_vld_next;
    logic [ENT_IDX_W-1:0]    addr_q_reg;
    logic                    ram_wr;
    logic [MASK_W:0]         ram_wr_data;
    logic [MASK_W:0]         ram_rd;

    // Each RAM word holds {alive, signature}; an entry without its valid bit reads as dead
    always_comb begin
        ent_vld_next = ent_vld_reg;
        if (cmd.alive_set || cmd.sig_wr) begin
            ent_vld_next[cmd.ent] = 1'b1;
        end
        // Kill drops the alive flag and the signature by invalidating the entry
        if (cmd.alive_clr) begin
            ent_vld_next[cmd.ent] = 1'b0;
        end
    end

    // A created entity always comes from the free list, so it starts with an empty signature
    assign ram_wr      = cmd.alive_set || cmd.sig_wr;
    assign ram_wr_data = cmd.alive_set ? {1'b1, {MASK_W{1'b0}}} : {1'b1, cmd.sig_data};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ent_vld_reg <= '0;
        end else begin
            ent_vld_reg <= ent_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            addr_q_reg <= req.rd_addr;
        end
    end

    eidsig_ram #(
        .WIDTH (MASK_W + 1),
        .DEPTH (MAX_ENTITIES)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr),
        .wr_addr (cmd.ent),
        .wr_data (ram_wr_data),
        .rd_en   (req.rd_en),
        .rd_addr (req.rd_addr),
        .rd_data (ram_rd)
    );

    assign rd.alive = ent_vld_reg[addr_q_reg] && ram_rd[MASK_W];
    assign rd.sig   = ent_vld_reg[addr_q_reg] ? ram_rd[MASK_W-1:0] : '0;

endmodule

/* dv/tb_entity_id_allocator_with_signatures.sv */
// Self-checking testbench of the entity table engine: directed rows, then random request streams.
`timescale 1ns / 1ps

module tb_entity_id_allocator_with_signatures;
    import eidsig_pkg::*;

    // Request codes past the defined set; the engine answers them with an empty result
    localparam logic [REQ_W-1:0] REQ_RSVD_LO = 3'd6;
    localparam logic [REQ_W-1:0] REQ_RSVD_HI = 3'd7;

    localparam int RANDOM_ITEMS = 230;
    // A query walks every entity; leave some margin past such a walk at the end
    localparam int SETTLE_CYCLES = MAX_ENTITIES + 16;
    localparam int MAX_IDLE = 13;

    // One result item, as it leaves on m_tdata/m_tlast
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic              valid;
        logic              alive;
        logic [STAT_W-1:0] status;
        logic              last;
    } ent_result_t;

    // One row of the directed part; typed rows carry their own single expected result
    typedef struct packed {
        logic [REQ_W-1:0]  req;
        logic [ID_W-1:0]   eid;
        logic [CID_W-1:0]  cid;
        logic [MASK_W-1:0] mask;
        logic              typed;
        ent_result_t       res;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tlast;

    // Shadow copy of the engine state
    logic [ID_W-1:0]   free_ring [MAX_ENTITIES];
    int                ring_head;
    int                ring_count;
    bit                alive_map [MAX_ENTITIES];
    logic [MASK_W-1:0] sig_map   [MAX_ENTITIES];

    ent_result_t expected_results [$];
    ent_result_t step_out [$];
    stim_row_t   stim_rows [$];

    int errors = 0;
    int items_sent = 0;
    bit tx_quiet = 1'b0;
    bit rx_quiet = 1'b0;
    int rx_stall = 0;

    entity_id_allocator_with_signatures u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Hard stop well past the slowest legal run
    initial begin
        #10_000_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic ent_result_t res(input logic [ID_W-1:0] id, input logic valid,
                                        input logic alive, input logic [STAT_W-1:0] status,
                                        input logic last);
        ent_result_t r;
        r.id = id;
        r.valid = valid;
        r.alive = alive;
        r.status = status;
        r.last = last;
        return r;
    endfunction

    // Append one predicted result of the current request
    task automatic emit(input ent_result_t r);
        step_out.insert(step_out.size(), r);
    endtask

    task automatic shadow_reset();
        for (int i = 0; i < MAX_ENTITIES; i++) begin
            free_ring[i] = ID_W'(i);
            alive_map[i] = 1'b0;
            sig_map[i] = '0;
        end
        ring_head = 0;
        ring_count = MAX_ENTITIES;
    endtask

    // Apply one accepted request to the shadow state and leave its results in step_out
    task automatic table_update(input logic [REQ_W-1:0] req, input logic [ID_W-1:0] eid,
                                input logic [CID_W-1:0] cid, input logic [MASK_W-1:0] mask);
        int                e;
        bit                ent_ok;
        bit                comp_ok;
        logic [MASK_W-1:0] cbit;
        logic [ID_W-1:0]   id;
        int                hits;
        e = int'(eid) % MAX_ENTITIES;
        ent_ok = (int'(eid) < MAX_ENTITIES) && alive_map[e];
        comp_ok = (cid >= 1) && (int'(cid) <= MAX_COMPONENT_TYPES);
        cbit = comp_ok ? (MASK_W'(1) << (cid - 1)) : '0;
        step_out.delete();
        case (req)
            REQ_CREATE: begin
                if (ring_count == 0) begin
                    emit(res('0, 1'b0, 1'b0, ST_NO_FREE, 1'b1));
                end else begin
                    id = free_ring[ring_head];
                    ring_head = (ring_head + 1) % MAX_ENTITIES;
                    ring_count--;
                    alive_map[id] = 1'b1;
                    emit(res(id, 1'b1, 1'b0, ST_OK, 1'b1));
                end
            end
            REQ_IS_ALIVE: begin
                if (int'(eid) >= MAX_ENTITIES)
                    emit(res('0, 1'b0, 1'b0, ST_NOT_ALIVE, 1'b1));
                else
                    emit(res('0, 1'b0, ent_ok, ST_OK, 1'b1));
            end
            REQ_KILL: begin
                if (!ent_ok) begin
                    emit(res('0, 1'b0, 1'b0, ST_NOT_ALIVE, 1'b1));
                end else begin
                    alive_map[e] = 1'b0;
                    sig_map[e] = '0;
                    if (ring_count < MAX_ENTITIES) begin
                        free_ring[(ring_head + ring_count) % MAX_ENTITIES] = ID_W'(e);
                        ring_count++;
                    end
                    emit(res('0, 1'b0, 1'b0, ST_OK, 1'b1));
                end
            end
            REQ_ADD, REQ_REMOVE: begin
                if (!ent_ok) begin
                    emit(res('0, 1'b0, 1'b0, ST_NOT_ALIVE, 1'b1));
                end else if (!comp_ok) begin
                    emit(res('0, 1'b0, 1'b0, ST_BAD_COMP, 1'b1));
                end else begin
                    if (req == REQ_ADD)
                        sig_map[e] = sig_map[e] | cbit;
                    else
                        sig_map[e] = sig_map[e] & ~cbit;
                    emit(res('0, 1'b0, 1'b0, ST_OK, 1'b1));
                end
            end
            REQ_QUERY: begin
                if ((mask & ~LEGAL_MASK) != '0) begin
                    emit(res('0, 1'b0, 1'b0, ST_BAD_COMP, 1'b1));
                end else begin
                    hits = 0;
                    for (int i = 0; i < MAX_ENTITIES; i++) begin
                        if (alive_map[i] && ((sig_map[i] & mask) == mask)) begin
                            emit(res(ID_W'(i), 1'b1, 1'b0, ST_OK, 1'b0));
                            hits++;
                        end
                    end
                    // Empty scan still answers once; otherwise mark the final match
                    if (hits == 0)
                        emit(res('0, 1'b0, 1'b0, ST_OK, 1'b1));
                    else
                        step_out[hits-1].last = 1'b1;
                end
            end
            default: emit(res('0, 1'b0, 1'b0, ST_OK, 1'b1));
        endcase
    endtask

    // Drive one request item: idle first, hold until accepted, then record what it should give.
    // tvalid is only lowered when an idle gap follows, so it never toggles within one step.
    task automatic issue(input logic [REQ_W-1:0] req, input logic [ID_W-1:0] eid,
                         input logic [CID_W-1:0] cid, input logic [MASK_W-1:0] mask,
                         input logic typed, input ent_result_t typed_res);
        int gap;
        if ($urandom_range(0, 15) == 0)
            tx_quiet = !tx_quiet;
        gap = tx_quiet ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {1'b0, mask, cid, eid, req};
        do @(posedge aclk); while (!s_tready);
        table_update(req, eid, cid, mask);
        if (typed)
            expected_results.insert(expected_results.size(), typed_res);
        else
            foreach (step_out[i]) expected_results.insert(expected_results.size(), step_out[i]);
        items_sent++;
    endtask

    task automatic send(input logic [REQ_W-1:0] req, input logic [ID_W-1:0] eid,
                        input logic [CID_W-1:0] cid, input logic [MASK_W-1:0] mask);
        issue(req, eid, cid, mask, 1'b0, '0);
    endtask

    // Stop sending until every outstanding result has come back
    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_results.size() != 0) @(posedge aclk);
    endtask

    task automatic add_row(input logic [REQ_W-1:0] req, input logic [ID_W-1:0] eid,
                           input logic [CID_W-1:0] cid, input logic [MASK_W-1:0] mask,
                           input logic typed, input ent_result_t r);
        stim_row_t row;
        row.req = req;
        row.eid = eid;
        row.cid = cid;
        row.mask = mask;
        row.typed = typed;
        row.res = r;
        stim_rows.insert(stim_rows.size(), row);
    endtask

    // Mostly address a live entity so that requests get past the alive check
    function automatic logic [ID_W-1:0] pick_entity();
        int live [$];
        for (int i = 0; i < MAX_ENTITIES; i++)
            if (alive_map[i]) live.insert(live.size(), i);
        if (live.size() != 0 && $urandom_range(0, 9) < 8)
            return ID_W'(live[$urandom_range(0, live.size() - 1)]);
        return ID_W'($urandom_range(0, MAX_ENTITIES - 1));
    endfunction

    // Crowd a few low components so that queries find matches; rarely go illegal
    function automatic logic [CID_W-1:0] pick_component();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 7)
            return CID_W'($urandom_range(1, 4));
        if (sel < 9)
            return CID_W'($urandom_range(1, MAX_COMPONENT_TYPES));
        return CID_W'($urandom_range(0, 63));
    endfunction

    function automatic logic [MASK_W-1:0] pick_mask();
        case ($urandom_range(0, 4))
            0: return '0;
            1, 2: return MASK_W'($urandom_range(0, 15));
            3: return MASK_W'(1) << $urandom_range(0, MASK_W - 1);
            default: return MASK_W'($urandom);
        endcase
    endfunction

    // Result side: random per-item stall on tready, check every accepted item in order
    always @(posedge aclk) begin : result_side
        ent_result_t got;
        ent_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_stall = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = res(m_tdata[5:0], m_tdata[6], m_tdata[7], m_tdata[9:8], m_tlast);
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result id=%0d valid=%0b alive=%0b status=%0d last=%0b",
                             $time, got.id, got.valid, got.alive, got.status, got.last);
                    errors++;
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        $display("%0t: mismatch expected id=%0d valid=%0b alive=%0b status=%0d last=%0b",
                                 $time, want.id, want.valid, want.alive, want.status, want.last);
                        $display("%0t:          actual   id=%0d valid=%0b alive=%0b status=%0d last=%0b",
                                 $time, got.id, got.valid, got.alive, got.status, got.last);
                        errors++;
                    end
                end
                if ($urandom_range(0, 15) == 0)
                    rx_quiet = !rx_quiet;
                rx_stall = rx_quiet ? 0 : $urandom_range(0, MAX_IDLE);
            end
            if (rx_stall > 0) begin
                rx_stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        int seq;
        int n;
        logic [ID_W-1:0] eid;
        shadow_reset();

        // Fresh table: nothing alive, every id free in order
        add_row(REQ_IS_ALIVE, 6'd0, 6'd0, '0, 1'b1, res('0, 1'b0, 1'b0, ST_OK, 1'b1));
        add_row(REQ_KILL, 6'd0, 6'd0, '0, 1'b1, res('0, 1'b0, 1'b0, ST_NOT_ALIVE, 1'b1));
        add_row(REQ_ADD, 6'd5, 6'd1, '0, 1'b1, res('0, 1'b0, 1'b0, ST_NOT_ALIVE, 1'b1));
        add_row(REQ_REMOVE, 6'd63, 6'd32, '0, 1'b1,
                res('0, 1'b0, 1'b0, ST_NOT_ALIVE, 1'b1));
        add_row(REQ_QUERY, 6'd0, 6'd0, '0, 1'b1, res('0, 1'b0, 1'b0, ST_OK, 1'b1));
        add_row(REQ_CREATE, 6'd0, 6'd0, '0, 1'b1, res(6'd0, 1'b1, 1'b0, ST_OK, 1'b1));
        add_row(REQ_CREATE, 6'd63, 6'd63, '1, 1'b1, res(6'd1, 1'b1, 1'b0, ST_OK, 1'b1));
        add_row(REQ_IS_ALIVE, 6'd1, 6'd0, '0, 1'b1, res('0, 1'b0, 1'b1, ST_OK, 1'b1));
        // Bad component ids on a live entity: zero, just past the top, all ones
        add_row(REQ_ADD, 6'd0, 6'd0, '0, 1'b1, res('0, 1'b0, 1'b0, ST_BAD_COMP, 1'b1));
        add_row(REQ_ADD, 6'd0, 6'd33, '0, 1'b1, res('0, 1'b0, 1'b0, ST_BAD_COMP, 1'b1));
        add_row(REQ_REMOVE, 6'd1, 6'd63, '0, 1'b1,
                res('0, 1'b0, 1'b0, ST_BAD_COMP, 1'b1));
        add_row(REQ_ADD, 6'd0, 6'd32, '0, 1'b0, '0);
        add_row(REQ_ADD, 6'd0, 6'd1, '0, 1'b0, '0);
        add_row(REQ_ADD, 6'd1, 6'd1, '0, 1'b0, '0);
        add_row(REQ_QUERY, 6'd0, 6'd0, 32'h8000_0001, 1'b0, '0);
        add_row(REQ_QUERY, 6'd0, 6'd0, 32'hFFFF_FFFF, 1'b0, '0);
        add_row(REQ_QUERY, 6'd0, 6'd0, '0, 1'b0, '0);
        add_row(REQ_REMOVE, 6'd0, 6'd32, '0, 1'b0, '0);
        add_row(REQ_RSVD_LO, 6'd63, 6'd63, 32'hFFFF_FFFF, 1'b1,
                res('0, 1'b0, 1'b0, ST_OK, 1'b1));
        add_row(REQ_RSVD_HI, 6'd0, 6'd1, '0, 1'b1, res('0, 1'b0, 1'b0, ST_OK, 1'b1));
        // Kill clears the signature and sends the id to the tail of the free list
        add_row(REQ_KILL, 6'd0, 6'd0, '0, 1'b1, res('0, 1'b0, 1'b0, ST_OK, 1'b1));
        add_row(REQ_IS_ALIVE, 6'd0, 6'd0, '0, 1'b1, res('0, 1'b0, 1'b0, ST_OK, 1'b1));
        add_row(REQ_CREATE, 6'd0, 6'd0, '0, 1'b1, res(6'd2, 1'b1, 1'b0, ST_OK, 1'b1));
        add_row(REQ_QUERY, 6'd0, 6'd0, 32'h0000_0001, 1'b0, '0);

        // Hold reset, then release it on a rising edge
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (stim_rows[i])
            issue(stim_rows[i].req, stim_rows[i].eid, stim_rows[i].cid, stim_rows[i].mask,
                  stim_rows[i].typed, stim_rows[i].res);
        hold_until_drained();

        // Random part: short well-formed sequences with random content, plus noise
        while (items_sent < stim_rows.size() + RANDOM_ITEMS) begin
            seq = $urandom_range(0, 11);
            case (seq)
                0: begin
                    // Run the free list dry and push past it
                    n = ring_count + $urandom_range(1, 2);
                    repeat (n) send(REQ_CREATE, ID_W'($urandom), CID_W'($urandom), $urandom);
                end
                1, 2, 3: begin
                    if (ring_count == MAX_ENTITIES)
                        send(REQ_CREATE, '0, '0, '0);
                    eid = pick_entity();
                    repeat ($urandom_range(1, 4))
                        send(($urandom_range(0, 3) == 0) ? REQ_REMOVE : REQ_ADD, eid,
                             pick_component(), pick_mask());
                end
                4, 5: repeat ($urandom_range(1, 6))
                    send(REQ_KILL, pick_entity(), pick_component(), pick_mask());
                6, 7: repeat ($urandom_range(1, 2))
                    send(REQ_QUERY, ID_W'($urandom), CID_W'($urandom), pick_mask());
                8: repeat ($urandom_range(1, 3))
                    send(REQ_IS_ALIVE, pick_entity(), CID_W'($urandom), $urandom);
                9: send(REQ_W'($urandom_range(0, 7)), ID_W'($urandom), CID_W'($urandom),
                        $urandom);
                10: repeat ($urandom_range(1, 3))
                    send(REQ_CREATE, ID_W'($urandom), CID_W'($urandom), $urandom);
                default: begin
                    // Let the engine drain completely, then query into an idle engine
                    hold_until_drained();
                    send(REQ_QUERY, '0, '0, pick_mask());
                end
            endcase
        end

        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
